// ===== rtl/dwisc_pkg.sv =====
// dwisc_pkg: shared types and constants for the dual-wheel integral speed control
// used by dwisc_wheel, dual_wheel_integral_speed_control and dwisc_checker
package dwisc_pkg;

	localparam int ENC_W   = 32;
	localparam int TGT_W   = 8;
	localparam int DRIVE_W = 9;
	localparam int DIR_W   = 2;
	localparam int DUTY_W  = 8;
	localparam int ILIM_W  = 15;
	localparam int CFG_W   = 15;
	localparam int IDX_W   = 3;
	localparam int IN_W    = 80;
	localparam int OUT_W   = 40;

	localparam logic [DIR_W-1:0] DIR_BRAKE = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
	localparam logic [DIR_W-1:0] DIR_REV   = 2'd2;

	localparam logic [IDX_W-1:0] CFG_PERIOD = 3'd0;
	localparam logic [IDX_W-1:0] CFG_GAIN   = 3'd1;
	localparam logic [IDX_W-1:0] CFG_ILIM   = 3'd2;
	localparam logic [IDX_W-1:0] CFG_PLIM   = 3'd3;
	localparam logic [IDX_W-1:0] CFG_OFFSET = 3'd4;

	// reciprocal of ten in 0.16 fixed point, exact for the duty range
	localparam logic [13:0] RECIP10 = 14'd6554;

	typedef struct packed {
		logic [7:0]        gain;
		logic [ILIM_W-1:0] ilim;
		logic [7:0]        plim;
		logic [7:0]        offset;
	} wheel_cfg_t;

	typedef struct packed {
		logic latch;
		logic ld1;
		logic ld2;
		logic ld3;
		logic ld4;
	} wheel_ctl_t;

endpackage

// ===== rtl/dwisc_wheel.sv =====
// dwisc_wheel: per-wheel datapath, four registered stages from speed error to duty
// depends on dwisc_pkg; stage enables come from the top level
module dwisc_wheel import dwisc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wheel_ctl_t                ctl,
	input  wheel_cfg_t                cfg,
	input  logic [ENC_W-1:0]          enc,
	input  logic signed [TGT_W-1:0]   tgt,
	output logic signed [DRIVE_W-1:0] drive,
	output logic [DIR_W-1:0]          dir,
	output logic [DUTY_W-1:0]         duty
);

	logic [15:0]         start_q;
	logic signed [15:0]  meas;
	logic signed [17:0]  err_c;
	logic signed [17:0]  err_s1;
	logic                zero_s1;
	logic signed [26:0]  prod_c;
	logic signed [26:0]  prod_s2;
	logic                zero_s2;
	logic signed [15:0]  integ_q;
	logic signed [27:0]  sum_c;
	logic signed [27:0]  lim_p;
	logic signed [27:0]  lim_n;
	logic signed [15:0]  acc_c;
	logic signed [15:0]  pl_p;
	logic signed [15:0]  pl_n;
	logic signed [15:0]  clamp_c;
	logic signed [DRIVE_W-1:0] drive_s3;
	logic [DRIVE_W-1:0]  neg_c;
	logic [7:0]          mag_c;
	logic [11:0]         nine_c;
	logic [25:0]         tenth_c;
	logic [8:0]          sum_duty_c;
	logic [DUTY_W-1:0]   duty_c;
	logic [DIR_W-1:0]    dir_c;

	// encoder delta wraps to 16 bits, so only the low half of the start count matters
	assign meas  = $signed(enc[15:0] - start_q);
	assign err_c = $signed({{10{tgt[7]}}, tgt}) - $signed({{2{meas[15]}}, meas});

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			start_q <= enc[15:0];
		end
		if (ctl.ld1) begin
			err_s1  <= err_c;
			zero_s1 <= (tgt == '0);
		end
	end

	assign prod_c = err_s1 * $signed({1'b0, cfg.gain});

	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			prod_s2 <= prod_c;
			zero_s2 <= zero_s1;
		end
	end

	// integrate with saturation (cleared when the target is zero), then clamp to the power limit
	assign sum_c = $signed({{12{integ_q[15]}}, integ_q}) + $signed({prod_s2[26], prod_s2});
	assign lim_p = $signed({13'd0, cfg.ilim});
	assign lim_n = -lim_p;
	assign pl_p  = $signed({8'd0, cfg.plim});
	assign pl_n  = -pl_p;

	always_comb begin
		if (zero_s2) begin
			acc_c = '0;
		end else if (sum_c > lim_p) begin
			acc_c = lim_p[15:0];
		end else if (sum_c < lim_n) begin
			acc_c = lim_n[15:0];
		end else begin
			acc_c = sum_c[15:0];
		end
		if (acc_c > pl_p) begin
			clamp_c = pl_p;
		end else if (acc_c < pl_n) begin
			clamp_c = pl_n;
		end else begin
			clamp_c = acc_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (ctl.ld3) begin
			integ_q <= acc_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld3) begin
			drive_s3 <= clamp_c[DRIVE_W-1:0];
		end
	end

	// duty = floor(9*|drive|/10) + offset, saturated; zero when drive is zero
	assign neg_c      = 9'(-drive_s3);
	assign mag_c      = drive_s3[DRIVE_W-1] ? neg_c[7:0] : drive_s3[7:0];
	assign nine_c     = {1'b0, mag_c, 3'b000} + {4'd0, mag_c};
	assign tenth_c    = nine_c * RECIP10;
	assign sum_duty_c = {1'b0, tenth_c[23:16]} + {1'b0, cfg.offset};

	always_comb begin
		if (mag_c == '0) begin
			duty_c = '0;
		end else if (sum_duty_c[8]) begin
			duty_c = 8'hff;
		end else begin
			duty_c = sum_duty_c[7:0];
		end
		if (drive_s3 == '0) begin
			dir_c = DIR_BRAKE;
		end else if (drive_s3[DRIVE_W-1]) begin
			dir_c = DIR_REV;
		end else begin
			dir_c = DIR_FWD;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld4) begin
			drive <= drive_s3;
			dir   <= dir_c;
			duty  <= duty_c;
		end
	end

endmodule

// ===== rtl/dual_wheel_integral_speed_control.sv =====
// dual_wheel_integral_speed_control: top level, tick sequencing, config and stream handshake
// depends on dwisc_pkg and dwisc_wheel
//
// Each request on the input stream is one timer tick carrying both encoder counts and both
// target speeds; a tick is taken in every clock cycle unless four results sit behind a
// stalled output. The first tick latches the encoder counts, the following period_ticks
// ticks (at least one) count down, and the last of them runs one integral update for both
// wheels and yields one result, so one result appears per max(period_ticks, 1) + 1 ticks.
// The update runs through four registered stages in order (speed error, gain multiply,
// integrator with saturation and drive clamp, duty scaling); the output register lets
// ticks keep flowing while a result waits to be taken. Configuration must be written
// through cfg_we/cfg_index/cfg_data only while no update is in flight; the block itself
// does not enforce this.
module dual_wheel_integral_speed_control import dwisc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// encoder_left, encoder_right, target_left, target_right
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// drive_left, drive_right, direction_left, direction_right, duty_left, duty_right, pad
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [7:0]  period_q;
	wheel_cfg_t  cfg_q;
	logic        phase_q;
	logic [7:0]  ticks_q;
	logic        v_s1, v_s2, v_s3, v_s4;
	logic        rdy1, rdy2, rdy3, rdy4;
	logic        take;
	logic        upd;
	wheel_ctl_t  ctl;

	logic signed [DRIVE_W-1:0] drive_l, drive_r;
	logic [DIR_W-1:0]          dir_l, dir_r;
	logic [DUTY_W-1:0]         duty_l, duty_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= 8'd2;
			cfg_q.gain   <= 8'd1;
			cfg_q.ilim   <= 15'd500;
			cfg_q.plim   <= 8'd210;
			cfg_q.offset <= 8'd25;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PERIOD: period_q     <= cfg_data[7:0];
				CFG_GAIN:   cfg_q.gain   <= cfg_data[7:0];
				CFG_ILIM:   cfg_q.ilim   <= cfg_data;
				CFG_PLIM:   cfg_q.plim   <= cfg_data[7:0];
				CFG_OFFSET: cfg_q.offset <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign rdy4     = !v_s4 || m_tready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign take     = s_tvalid && s_tready;
	assign upd      = take && phase_q && (ticks_q <= 8'd1);

	assign ctl.latch = take && !phase_q;
	assign ctl.ld1   = upd;
	assign ctl.ld2   = v_s1 && rdy2;
	assign ctl.ld3   = v_s2 && rdy3;
	assign ctl.ld4   = v_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			ticks_q <= '0;
		end else if (take) begin
			if (!phase_q) begin
				phase_q <= 1'b1;
				ticks_q <= period_q;
			end else if (ticks_q > 8'd1) begin
				ticks_q <= ticks_q - 8'd1;
			end else begin
				phase_q <= 1'b0;
				ticks_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= upd;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	dwisc_wheel u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cfg    (cfg_q),
		.enc    (s_tdata[31:0]),
		.tgt    ($signed(s_tdata[71:64])),
		.drive  (drive_l),
		.dir    (dir_l),
		.duty   (duty_l)
	);

	dwisc_wheel u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cfg    (cfg_q),
		.enc    (s_tdata[63:32]),
		.tgt    ($signed(s_tdata[79:72])),
		.drive  (drive_r),
		.dir    (dir_r),
		.duty   (duty_r)
	);

	assign m_tvalid = v_s4;
	assign m_tdata  = {2'b00, duty_r, duty_l, dir_r, dir_l, drive_r, drive_l};

endmodule

// ===== rtl/dwisc_checker.sv =====
// dwisc_checker: port-level assertions for dual_wheel_integral_speed_control
// depends on dwisc_pkg; bound to the top level below
module dwisc_checker import dwisc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// direction follows drive sign on both wheels
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
		((m_tdata[8:0] == 9'd0) == (m_tdata[19:18] == DIR_BRAKE)) &&
		(m_tdata[8] == (m_tdata[19:18] == DIR_REV)) &&
		((m_tdata[17:9] == 9'd0) == (m_tdata[21:20] == DIR_BRAKE)) &&
		(m_tdata[17] == (m_tdata[21:20] == DIR_REV)))
		else $error("direction does not match drive");

	// duty is zero when braking, and the pad bits are zero
	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
		((m_tdata[19:18] != DIR_BRAKE) || (m_tdata[29:22] == 8'd0)) &&
		((m_tdata[21:20] != DIR_BRAKE) || (m_tdata[37:30] == 8'd0)) &&
		(m_tdata[39:38] == 2'b00))
		else $error("duty inconsistent with direction");

	// empty output never blocks ticks
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind dual_wheel_integral_speed_control dwisc_checker u_chk (.*);
